/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LFDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfdc assertion failed");

// next-cycle implication
`define LFDC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfdc assertion failed");

`endif

/* rtl/core/lfdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfdc_pkg
// Types, constants and pattern helpers for the line follower drive control.
// ----------------------------------------------------------------------------
package lfdc_pkg;

	localparam int SENSOR_N   = 8;
	localparam int DUTY_W     = 7;
	localparam int ERR_W      = 5;
	localparam int GAIN_W     = 4;
	localparam int THR_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int SUM_W      = 6;
	localparam int CNT_W      = 4;
	localparam int PROD_W     = 10;
	localparam int DRV_W      = 11;

	typedef logic [DUTY_W-1:0]        duty_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic [SENSOR_N-1:0]      sensor_t;

	typedef enum logic [1:0] {
		MODE_PROP  = 2'd0,
		MODE_RIGHT = 2'd1,
		MODE_LEFT  = 2'd2,
		MODE_HOLD  = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_BASE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT     = 3'd4;

	localparam logic [GAIN_W-1:0] RST_STEER_GAIN      = 4'd9;
	localparam duty_t             RST_STRAIGHT_BASE   = 7'd23;
	localparam duty_t             RST_CURVE_BASE      = 7'd12;
	localparam logic [THR_W-1:0]  RST_CURVE_THRESHOLD = 4'd4;
	localparam duty_t             RST_DRIVE_LIMIT     = 7'd99;

	localparam duty_t PIVOT_DUTY_1 = 7'd45;
	localparam duty_t PIVOT_DUTY_2 = 7'd50;
	localparam duty_t PIVOT_DUTY_3 = 7'd55;
	localparam duty_t PIVOT_DUTY_4 = 7'd60;

	typedef struct packed {
		mode_t mode;
		duty_t duty_a;
		duty_t duty_b;
	} pattern_t;

	typedef struct packed {
		logic                   start;
		logic [ERR_W-1:0]       dividend;
		logic [CNT_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [ERR_W-1:0]       quotient;
	} div_rsp_t;

	function automatic logic signed [SUM_W-1:0] sensor_weight(input logic [2:0] idx);
		logic signed [SUM_W-1:0] w;
		unique case (idx)
			3'd0: w = -6'sd12;
			3'd1: w = -6'sd5;
			3'd2: w = -6'sd3;
			3'd3: w = -6'sd1;
			3'd4: w = 6'sd1;
			3'd5: w = 6'sd3;
			3'd6: w = 6'sd5;
			3'd7: w = 6'sd12;
			default: w = '0;
		endcase
		return w;
	endfunction

	// Fixed drives for the edge-run and hold patterns; everything else is proportional.
	function automatic pattern_t classify(input sensor_t bits);
		pattern_t p;
		p = '{mode: MODE_PROP, duty_a: '0, duty_b: '0};
		unique case (bits)
			8'h03: p = '{mode: MODE_RIGHT, duty_a: '0, duty_b: PIVOT_DUTY_1};
			8'h07: p = '{mode: MODE_RIGHT, duty_a: '0, duty_b: PIVOT_DUTY_2};
			8'h0F: p = '{mode: MODE_RIGHT, duty_a: '0, duty_b: PIVOT_DUTY_3};
			8'h1F: p = '{mode: MODE_RIGHT, duty_a: '0, duty_b: PIVOT_DUTY_4};
			8'hC0: p = '{mode: MODE_LEFT, duty_a: PIVOT_DUTY_1, duty_b: '0};
			8'hE0: p = '{mode: MODE_LEFT, duty_a: PIVOT_DUTY_2, duty_b: '0};
			8'hF0: p = '{mode: MODE_LEFT, duty_a: PIVOT_DUTY_3, duty_b: '0};
			8'hF8: p = '{mode: MODE_LEFT, duty_a: PIVOT_DUTY_4, duty_b: '0};
			8'hFF, 8'h00, 8'h81: p = '{mode: MODE_HOLD, duty_a: '0, duty_b: '0};
			default: p = '{mode: MODE_PROP, duty_a: '0, duty_b: '0};
		endcase
		return p;
	endfunction

endpackage

/* rtl/core/lfdc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfdc_if
// Valid/ready channels for sensor vectors in and drive results out.
// ----------------------------------------------------------------------------
interface lfdc_sensor_if import lfdc_pkg::*;;
	logic    valid;
	logic    ready;
	sensor_t sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lfdc_drive_if import lfdc_pkg::*;;
	logic  valid;
	logic  ready;
	duty_t drive_a;
	duty_t drive_b;
	err_t  position_error;
	mode_t drive_mode;

	modport source (output valid, output drive_a, output drive_b,
		output position_error, output drive_mode, input ready);
	modport sink   (input valid, input drive_a, input drive_b,
		input position_error, input drive_mode, output ready);
endinterface

/* rtl/core/lfdc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfdc_divider
// Restoring divider, one quotient bit per cycle, for the error magnitude.
// ----------------------------------------------------------------------------
module lfdc_divider import lfdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int DIV_STEPS = ERR_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	logic [CNT_W-1:0]  rem_q;
	logic [ERR_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, dvd_q[ERR_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[ERR_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

/* rtl/core/line_follower_drive_control_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_drive_control_unit
// Weighted line position, P steering and pivot/hold drive selection.
// ----------------------------------------------------------------------------
// channel     dir  payload                                          handshake
// sensor_in   in   sensor_bits[7:0]                                 valid/ready
// drive_out   out  drive_a[6:0] drive_b[6:0] position_error[4:0]   valid/ready
//                  drive_mode[1:0]
// cfg         in   cfg_index[2:0] cfg_wdata[6:0]                    cfg_we
//
// An item goes from accept through S_DIV, S_MUL and S_DONE to the result
// register. A vector with no sensor set skips the 5-step restoring divider.
// sensor_in.ready is high only while idle; a result waiting on drive_out holds
// the finish step until the output register is free.
// Reset clears the held error and last drives and loads the register defaults.
// ----------------------------------------------------------------------------
module line_follower_drive_control_unit import lfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	lfdc_sensor_if.sink           sensor_in,
	lfdc_drive_if.source          drive_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_MUL  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0] gain_q;
	duty_t             straight_q;
	duty_t             curve_q;
	logic [THR_W-1:0]  thr_q;
	duty_t             limit_q;

	err_t              held_q;
	duty_t             last_a_q;
	duty_t             last_b_q;

	sensor_t           bits_q;
	duty_t             base_q;
	logic              neg_q;
	err_t              err_q;
	logic signed [PROD_W-1:0] prod_q;

	logic              out_valid_q;
	duty_t             out_a_q;
	duty_t             out_b_q;
	err_t              out_err_q;
	mode_t             out_mode_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic signed [SUM_W-1:0] sum;
	logic [CNT_W-1:0]  cnt;
	logic [ERR_W-1:0]  held_mag;
	logic [ERR_W-1:0]  sum_mag;
	logic              accept;
	logic              finish;
	pattern_t          pat;
	logic signed [PROD_W-1:0] err_x;
	logic signed [PROD_W-1:0] gain_x;
	logic signed [DRV_W-1:0]  sum_a;
	logic signed [DRV_W-1:0]  sum_b;
	logic signed [DRV_W-1:0]  lim_x;
	duty_t             drv_a;
	duty_t             drv_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= RST_STEER_GAIN;
			straight_q <= RST_STRAIGHT_BASE;
			curve_q    <= RST_CURVE_BASE;
			thr_q      <= RST_CURVE_THRESHOLD;
			limit_q    <= RST_DRIVE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEER_GAIN:      gain_q     <= cfg_wdata[GAIN_W-1:0];
				CFG_STRAIGHT_BASE:   straight_q <= cfg_wdata[DUTY_W-1:0];
				CFG_CURVE_BASE:      curve_q    <= cfg_wdata[DUTY_W-1:0];
				CFG_CURVE_THRESHOLD: thr_q      <= cfg_wdata[THR_W-1:0];
				CFG_DRIVE_LIMIT:     limit_q    <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// weighted sum and population count over the eight sensors
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int i = 0; i < SENSOR_N; i++) begin
			if (sensor_in.sensor_bits[i]) begin
				sum = sum + sensor_weight(3'(i));
				cnt = cnt + 1'b1;
			end
		end
		sum_mag  = sum[SUM_W-1] ? ERR_W'(-sum) : ERR_W'(sum);
		held_mag = held_q[ERR_W-1] ? ERR_W'(-held_q) : ERR_W'(held_q);
	end

	assign sensor_in.ready = (state_q == S_IDLE);
	assign accept          = sensor_in.valid && sensor_in.ready;

	assign div_req.start    = accept && (cnt != '0);
	assign div_req.dividend = sum_mag;
	assign div_req.divisor  = cnt;

	lfdc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// proportional drives and their clamps, overridden by the pivot and hold patterns
	always_comb begin
		err_x  = PROD_W'(err_q);
		gain_x = $signed({{(PROD_W-GAIN_W){1'b0}}, gain_q});
		sum_a  = $signed({{(DRV_W-DUTY_W){1'b0}}, base_q}) + DRV_W'(prod_q);
		sum_b  = $signed({{(DRV_W-DUTY_W){1'b0}}, base_q}) - DRV_W'(prod_q);
		lim_x  = $signed({{(DRV_W-DUTY_W){1'b0}}, limit_q});
		pat    = classify(bits_q);
		priority if (sum_a < 0)     drv_a = '0;
		else if (sum_a > lim_x)     drv_a = limit_q;
		else                        drv_a = sum_a[DUTY_W-1:0];
		priority if (sum_b < 0)     drv_b = '0;
		else if (sum_b > lim_x)     drv_b = limit_q;
		else                        drv_b = sum_b[DUTY_W-1:0];
		unique case (pat.mode)
			MODE_PROP: ;
			MODE_HOLD: begin
				drv_a = last_a_q;
				drv_b = last_b_q;
			end
			default: begin
				drv_a = pat.duty_a;
				drv_b = pat.duty_b;
			end
		endcase
	end

	assign finish = (state_q == S_DONE) && (!out_valid_q || drive_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= '0;
			last_a_q    <= '0;
			last_b_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
				last_a_q    <= drv_a;
				last_b_q    <= drv_b;
			end else if (drive_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cnt == '0) ? S_MUL : S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					held_q  <= err_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_q <= sensor_in.sensor_bits;
			base_q <= (held_mag >= {1'b0, thr_q}) ? curve_q : straight_q;
			neg_q  <= sum[SUM_W-1];
			// empty vector keeps the held error
			if (cnt == '0) begin
				err_q <= held_q;
			end
		end
		if (state_q == S_DIV && div_rsp.done) begin
			err_q <= neg_q ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
		end
		if (state_q == S_MUL) begin
			prod_q <= err_x * gain_x;
		end
		if (finish) begin
			out_a_q    <= drv_a;
			out_b_q    <= drv_b;
			out_err_q  <= err_q;
			out_mode_q <= pat.mode;
		end
	end

	assign drive_out.valid          = out_valid_q;
	assign drive_out.drive_a        = out_a_q;
	assign drive_out.drive_b        = out_b_q;
	assign drive_out.position_error = out_err_q;
	assign drive_out.drive_mode     = out_mode_q;

endmodule

/* rtl/core/lfdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfdc_checker
// Port-level checks on the drive control unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfdc_checker import lfdc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  drive_a,
	input logic [6:0]  drive_b,
	input logic [4:0]  position_error,
	input logic [1:0]  drive_mode
);

	`LFDC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`LFDC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_a) && $stable(drive_b) && $stable(position_error) && $stable(drive_mode))
	`LFDC_ASSERT_IMP(a_err_range, out_valid, $signed(position_error) >= -5'sd12 && $signed(position_error) <= 5'sd12)
	`LFDC_ASSERT_IMP(a_pivot_side, out_valid && drive_mode == MODE_RIGHT, drive_a == '0)

endmodule

bind line_follower_drive_control_unit lfdc_checker u_lfdc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sensor_in.valid),
	.in_ready       (sensor_in.ready),
	.out_valid      (drive_out.valid),
	.out_ready      (drive_out.ready),
	.drive_a        (drive_out.drive_a),
	.drive_b        (drive_out.drive_b),
	.position_error (drive_out.position_error),
	.drive_mode     (drive_out.drive_mode)
);

/* dv/lfdc_drive_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfdc_drive_checker
// Watches the sensor, drive and register channels of the drive control unit.
// Predicts every drive result from the accepted sensor vectors and compares it
// field by field with the beats leaving the block.
// ----------------------------------------------------------------------------
module lfdc_drive_checker import lfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	lfdc_sensor_if                sensor_mon,
	lfdc_drive_if                 drive_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    failures,
	output int                    pending
);

	typedef struct {
		duty_t drive_a;
		duty_t drive_b;
		err_t  pos_err;
		mode_t mode;
	} drive_beat_t;

	logic [GAIN_W-1:0] steer_gain;
	duty_t             straight_base;
	duty_t             curve_base;
	logic [THR_W-1:0]  curve_thr;
	duty_t             drive_limit;

	int                held_err;
	duty_t             last_a;
	duty_t             last_b;

	drive_beat_t       drive_expect_q[$];
	drive_beat_t       want;
	int                mismatch_count = 0;

	function automatic int lane_weight(input int lane);
		case (lane)
			0: return -12;
			1: return -5;
			2: return -3;
			3: return -1;
			4: return 1;
			5: return 3;
			6: return 5;
			default: return 12;
		endcase
	endfunction

	function automatic duty_t clamp_duty(input int v);
		if (v > int'(drive_limit))
			v = int'(drive_limit);
		if (v < 0)
			v = 0;
		return duty_t'(v);
	endfunction

	// Advance the steering state by one sensor vector and return its drives.
	function automatic drive_beat_t steer_step(input sensor_t bits);
		drive_beat_t r;
		int mag;
		int base;
		int sum;
		int cnt;
		int p;
		mag = (held_err < 0) ? -held_err : held_err;
		base = (mag >= int'(curve_thr)) ? int'(curve_base) : int'(straight_base);
		sum = 0;
		cnt = 0;
		for (int i = 0; i < SENSOR_N; i++) begin
			if (bits[i]) begin
				sum += lane_weight(i);
				cnt++;
			end
		end
		if (cnt != 0)
			held_err = sum / cnt;
		case (bits)
			8'h03: begin r.drive_a = '0; r.drive_b = PIVOT_DUTY_1; r.mode = MODE_RIGHT; end
			8'h07: begin r.drive_a = '0; r.drive_b = PIVOT_DUTY_2; r.mode = MODE_RIGHT; end
			8'h0F: begin r.drive_a = '0; r.drive_b = PIVOT_DUTY_3; r.mode = MODE_RIGHT; end
			8'h1F: begin r.drive_a = '0; r.drive_b = PIVOT_DUTY_4; r.mode = MODE_RIGHT; end
			8'hC0: begin r.drive_a = PIVOT_DUTY_1; r.drive_b = '0; r.mode = MODE_LEFT; end
			8'hE0: begin r.drive_a = PIVOT_DUTY_2; r.drive_b = '0; r.mode = MODE_LEFT; end
			8'hF0: begin r.drive_a = PIVOT_DUTY_3; r.drive_b = '0; r.mode = MODE_LEFT; end
			8'hF8: begin r.drive_a = PIVOT_DUTY_4; r.drive_b = '0; r.mode = MODE_LEFT; end
			8'hFF, 8'h00, 8'h81: begin
				r.drive_a = last_a;
				r.drive_b = last_b;
				r.mode = MODE_HOLD;
			end
			default: begin
				p = held_err * int'(steer_gain);
				r.drive_a = clamp_duty(base + p);
				r.drive_b = clamp_duty(base - p);
				r.mode = MODE_PROP;
			end
		endcase
		last_a = r.drive_a;
		last_b = r.drive_b;
		r.pos_err = err_t'(held_err);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] drive_out %s: got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_gain = RST_STEER_GAIN;
			straight_base = RST_STRAIGHT_BASE;
			curve_base = RST_CURVE_BASE;
			curve_thr = RST_CURVE_THRESHOLD;
			drive_limit = RST_DRIVE_LIMIT;
			held_err = 0;
			last_a = '0;
			last_b = '0;
			drive_expect_q.delete();
			pending <= 0;
			failures <= mismatch_count;
		end else begin
			// only the low bits of narrow registers are kept
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEER_GAIN:      steer_gain = cfg_wdata[GAIN_W-1:0];
					CFG_STRAIGHT_BASE:   straight_base = cfg_wdata;
					CFG_CURVE_BASE:      curve_base = cfg_wdata;
					CFG_CURVE_THRESHOLD: curve_thr = cfg_wdata[THR_W-1:0];
					CFG_DRIVE_LIMIT:     drive_limit = cfg_wdata;
					default: ;
				endcase
			end
			if (sensor_mon.valid && sensor_mon.ready)
				drive_expect_q.push_back(steer_step(sensor_mon.sensor_bits));
			if (drive_mon.valid && drive_mon.ready) begin
				if (drive_expect_q.size() == 0) begin
					report_mismatch("beat with nothing expected, drive_a",
						int'(drive_mon.drive_a), -1);
				end else begin
					want = drive_expect_q.pop_front();
					if (drive_mon.drive_a !== want.drive_a)
						report_mismatch("drive_a", int'(drive_mon.drive_a), int'(want.drive_a));
					if (drive_mon.drive_b !== want.drive_b)
						report_mismatch("drive_b", int'(drive_mon.drive_b), int'(want.drive_b));
					if (drive_mon.position_error !== want.pos_err)
						report_mismatch("position_error", int'($signed(drive_mon.position_error)),
							int'($signed(want.pos_err)));
					if (drive_mon.drive_mode !== want.mode)
						report_mismatch("drive_mode", int'(drive_mon.drive_mode), int'(want.mode));
				end
			end
			pending <= drive_expect_q.size();
			failures <= mismatch_count;
		end
	end

endmodule

/* dv/line_follower_drive_control_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_drive_control_unit_test
// Drives sensor vectors and register settings into the drive control unit,
// with random idling on both channels and long output stalls, and leaves the
// checking to the drive checker beside the block.
// ----------------------------------------------------------------------------
module line_follower_drive_control_unit_test;
	import lfdc_pkg::*;

	localparam int STALL_LIMIT    = 5000;
	localparam int HOLD_OFF_BEATS = 200;
	localparam int PHASE_ITEMS    = 255;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    failures;
	int                    pending;
	int                    quiet_cycles = 0;
	bit                    calm = 1'b0;
	bit                    hold_off_req = 1'b0;

	lfdc_sensor_if sensor_ch();
	lfdc_drive_if  drive_ch();

	line_follower_drive_control_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor_in (sensor_ch),
		.drive_out (drive_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	lfdc_drive_checker steer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sensor_mon (sensor_ch),
		.drive_mon  (drive_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.failures   (failures),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sensor_ch.valid && sensor_ch.ready) || (drive_ch.valid && drive_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		drive_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				drive_ch.ready <= 1'b0;
				repeat (HOLD_OFF_BEATS) @(posedge clk);
			end
			drive_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
			@(posedge clk);
		end
	end

	task automatic send_vector(input sensor_t bits);
		if (!calm) begin
			while ($urandom_range(0, 99) < 15) begin
				sensor_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.sensor_bits <= bits;
		do
			@(posedge clk);
		while (!sensor_ch.ready);
	endtask

	// Wait until every result is back, then let the pipeline settle.
	task automatic drain_results();
		do
			@(posedge clk);
		while (pending != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] gain, sbase, cbase, thr, lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STEER_GAIN;
		cfg_wdata <= gain;
		@(posedge clk);
		cfg_index <= CFG_STRAIGHT_BASE;
		cfg_wdata <= sbase;
		@(posedge clk);
		cfg_index <= CFG_CURVE_BASE;
		cfg_wdata <= cbase;
		@(posedge clk);
		cfg_index <= CFG_CURVE_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= CFG_DRIVE_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Narrow runs as seen over a real line are the commonest, then noise, then fixed patterns.
	function automatic sensor_t pick_vector();
		int roll;
		int w;
		int s;
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			case ($urandom_range(0, 10))
				0: return 8'h03;
				1: return 8'h07;
				2: return 8'h0F;
				3: return 8'h1F;
				4: return 8'hC0;
				5: return 8'hE0;
				6: return 8'hF0;
				7: return 8'hF8;
				8: return 8'hFF;
				9: return 8'h00;
				default: return 8'h81;
			endcase
		end else if (roll < 70) begin
			w = $urandom_range(1, 3);
			s = $urandom_range(0, SENSOR_N - w);
			return sensor_t'(((1 << w) - 1) << s);
		end
		return sensor_t'($urandom_range(0, 255));
	endfunction

	initial begin
		sensor_t directed_vecs[$];
		arst_n = 1'b0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.sensor_bits <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_STEER_GAIN;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hold before any drive, both far edges, every pivot, then spread patterns
		directed_vecs = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h81, 8'h03, 8'h07, 8'h0F,
			8'h1F, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'h18, 8'h08, 8'h10, 8'h02, 8'h40,
			8'hAA, 8'h55, 8'h00};
		foreach (directed_vecs[i])
			send_vector(directed_vecs[i]);
		sensor_ch.valid <= 1'b0;
		drain_results();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(7'd15, 7'd127, 7'd127, 7'd0, 7'd127);
				1: apply_settings(7'd0, 7'd0, 7'd0, 7'd15, 7'd0);
				3: apply_settings(7'd15, 7'd64, 7'd20, 7'd13, 7'd50);
				default: apply_settings(CFG_DATA_W'($urandom_range(0, 127)),
					CFG_DATA_W'($urandom_range(0, 127)),
					CFG_DATA_W'($urandom_range(0, 127)),
					CFG_DATA_W'($urandom_range(0, 127)),
					CFG_DATA_W'($urandom_range(0, 127)));
			endcase
			calm = (phase == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == 100 && (phase == 1 || phase == 4))
					hold_off_req = 1'b1;
				send_vector(pick_vector());
			end
			sensor_ch.valid <= 1'b0;
			calm = 1'b0;
			drain_results();
		end

		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lfdc_pkg.sv
rtl/core/lfdc_if.sv
rtl/core/lfdc_divider.sv
rtl/core/line_follower_drive_control_unit.sv
rtl/core/lfdc_checker.sv
dv/lfdc_drive_checker.sv
dv/line_follower_drive_control_unit_test.sv
